### rtl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int LIMIT_W       = 5;
    localparam int FILL_W        = 5;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 72;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    // Word index of the capacity limit register.
    localparam logic REG_CAPACITY_LIMIT = 1'b0;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] rank;
    } spq_entry_t;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic       ins;
        logic       rem;
        spq_entry_t item;
    } spq_ctl_t;

endpackage

### rtl/spq_cell.sv
module spq_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  spq_pkg::spq_ctl_t  ctl,
    input  logic [CW-1:0]      count,
    input  spq_pkg::spq_entry_t left_entry,
    input  logic               left_after,
    input  spq_pkg::spq_entry_t right_entry,
    output spq_pkg::spq_entry_t entry,
    output logic               after
);
    import spq_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;
    logic       occupied;
    logic       greater;

    // The cell holds an entry when its place lies below the fill count.
    assign occupied = IDX < count;
    assign greater  = occupied && (entry_reg.rank > ctl.item.rank);

    // True when the new entry lands here or further toward the head.
    assign after = !occupied || greater;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (after && left_after)
            begin
                entry_next = left_entry;
            end
            else if (after)
            begin
                entry_next = ctl.item;
            end
        end
        else if (ctl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/sorted_priority_queue_top.sv
// Sorted priority queue. Each request on the slave stream either inserts a
// (value, rank) entry or removes the head entry, as selected by s_tuser, and
// produces exactly one response on the master stream carrying the status,
// the removed entry and the fill count after the step. Entries are kept in a
// row of cells sorted by ascending signed rank; entries of equal rank leave
// in arrival order. Every cell compares its own rank with the incoming one
// and shifts toward the tail or the head in the same clock, and the queue
// accepts a new request every cycle, also while a response waits in the
// output register, as long as that response is taken. An insert is refused
// with a full status once the fill count reaches the capacity limit
// register (saturated at DEPTH); a removal from an empty queue reports an
// empty status. Removed fields are zero unless an entry actually left.
// Lowering the limit below the fill count keeps the held entries. The limit
// should be written only while no request is in flight.
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, low bits up: item_value[31:0], item_rank[63:32].
    input  logic [spq_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: mode[0].
    input  logic                              s_tuser,
    // Response stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, low bits up: status[1:0], removed_value[33:2],
    // removed_rank[65:34], fill_count[70:66], zero pad.
    output logic [spq_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spq_pkg::ADDR_W-1:0]        paddr,
    input  logic [spq_pkg::DATA_W-1:0]        pwdata,
    output logic [spq_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import spq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // Fill count and capacity limit.
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [LIMIT_W-1:0] limit_reg;

    // Response register.
    logic                      m_tvalid_reg;
    spq_status_t               status_reg;
    logic signed [VALUE_W-1:0] removed_value_reg;
    logic signed [VALUE_W-1:0] removed_rank_reg;
    logic [FILL_W-1:0]         fill_count_reg;

    spq_status_t               status_next;
    logic signed [VALUE_W-1:0] removed_value_next;
    logic signed [VALUE_W-1:0] removed_rank_next;

    logic       s_accept;
    logic       req_mode;
    spq_entry_t req_item;
    logic       full;
    logic       empty;
    logic       cfg_write;
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] count_next_ext;
    spq_ctl_t   ctl;

    spq_entry_t cell_entry [DEPTH];
    logic       cell_after [DEPTH];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign req_mode       = s_tuser;
    assign req_item.value = s_tdata[VALUE_W-1:0];
    assign req_item.rank  = s_tdata[2*VALUE_W-1:VALUE_W];

    // The effective capacity is the limit register saturated at DEPTH.
    assign count_ext = CMPW'(count_reg);
    assign full      = (count_ext >= CMPW'(limit_reg)) || (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctl.ins  = s_accept && (req_mode == MODE_INSERT) && !full;
    assign ctl.rem  = s_accept && (req_mode == MODE_REMOVE) && !empty;
    assign ctl.item = req_item;

    always_comb
    begin
        count_next         = count_reg;
        status_next        = ST_DONE;
        removed_value_next = '0;
        removed_rank_next  = '0;
        if (req_mode == MODE_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                count_next         = count_reg - CW'(1);
                removed_value_next = cell_entry[0].value;
                removed_rank_next  = cell_entry[0].rank;
            end
        end
    end

    assign count_next_ext = CMPW'(count_next);

    // The chain of cells; the head sits in cell 0.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_entry_t left_entry;
        logic       left_after;
        spq_entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = req_item;
            assign left_after = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_after = cell_after[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell #(
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_after  (left_after),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .after       (cell_after[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            status_reg        <= status_next;
            removed_value_reg <= removed_value_next;
            removed_rank_reg  <= removed_rank_next;
            fill_count_reg    <= count_next_ext[FILL_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, fill_count_reg, removed_rank_reg, removed_value_reg, status_reg};

    // Configuration: one register, decoded on the word index.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_W-1] == REG_CAPACITY_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_CAPACITY_LIMIT) ?
                    DATA_W'(limit_reg) : '0;

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // A removal from an empty queue reports empty and leaves the count alone.
    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (req_mode == MODE_REMOVE) && empty
        |=> m_tvalid && (status_reg == ST_EMPTY) && (count_reg == '0))
        else $error("empty removal not reported");

    // A refused insert reports full and keeps the count.
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (req_mode == MODE_INSERT) && full
        |=> (status_reg == ST_FULL) && $stable(count_reg))
        else $error("refused insert changed state");

    // An accepted insert grows the queue by exactly one.
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> (count_reg == $past(count_reg) + CW'(1)) && (status_reg == ST_DONE))
        else $error("insert did not grow the queue");

    // The two entries nearest the head stay in rank order.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (cell_entry[0].rank <= cell_entry[1].rank))
        else $error("head entries out of order");

endmodule
